@@ rtl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg: shared definitions for the seven-segment scan driver
// Operation codes, field widths, blink timing and the digit glyph table.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned ICON_W     = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned POSITIONS  = 4;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned NUMBER_W   = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned COUNT_W    = 16;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_NUMBER = 3'd1;
  localparam logic [OP_W-1:0] OP_ERROR  = 3'd2;
  localparam logic [OP_W-1:0] OP_ICON   = 3'd3;
  localparam logic [OP_W-1:0] OP_VOLUME = 3'd4;
  localparam logic [OP_W-1:0] OP_BLINK  = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [VALUE_W-1:0]  NUMBER_LIMIT = 16'd999;
  localparam logic [VALUE_W-1:0]  ERROR_LIMIT  = 16'd9;

  localparam logic [COUNT_W-1:0]  BLINK_PERIOD = 16'd200;
  localparam logic [COUNT_W-1:0]  BLINK_HALF   = BLINK_PERIOD / 2;

  localparam logic [SEG_W-1:0] GLYPH_ERROR = 8'h9E;
  localparam logic [SEG_W-1:0] GLYPH_MINUS = 8'h02;

  localparam logic [ICON_W-1:0] ICON_POINT_1 = 4'd6;
  localparam logic [ICON_W-1:0] ICON_POINT_3 = 4'd7;
  localparam logic [ICON_W-1:0] ICON_POINT_2 = 4'd8;
  localparam int unsigned       VOLUME_STEPS = 6;

  typedef logic [SEG_W-1:0]   pattern_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Segment pattern for a decimal digit, bit 7 = A ... bit 1 = G, point clear.
  function automatic pattern_t glyph_of_digit(input digit_t d);
    pattern_t g;
    case (d)
      4'd0:    g = 8'hFC;
      4'd1:    g = 8'h60;
      4'd2:    g = 8'hDA;
      4'd3:    g = 8'hF2;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'hB6;
      4'd6:    g = 8'hBE;
      4'd7:    g = 8'hE0;
      4'd8:    g = 8'hFE;
      4'd9:    g = 8'hF6;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/ssd_if.sv @@
// ----------------------------------------------------------------------------
// ssd_if: valid/ready channels of the seven-segment scan driver
// Request channel carries update and tick items; result channel carries
// segment levels and the digit select.
// ----------------------------------------------------------------------------
interface ssd_req_if;
  logic                          valid;
  logic                          ready;
  logic [ssd_pkg::OP_W-1:0]      operation;
  logic [ssd_pkg::VALUE_W-1:0]   value;
  logic [ssd_pkg::ICON_W-1:0]    icon_index;
  logic                          switch_on;

  modport source (output valid, operation, value, icon_index, switch_on, input ready);
  modport sink   (input valid, operation, value, icon_index, switch_on, output ready);
endinterface

interface ssd_res_if;
  logic                          valid;
  logic                          ready;
  logic [ssd_pkg::SEG_W-1:0]     segment_levels;
  logic [ssd_pkg::POSITIONS-1:0] digit_select;

  modport source (output valid, segment_levels, digit_select, input ready);
  modport sink   (input valid, segment_levels, digit_select, output ready);
endinterface

@@ rtl/ssd_digit_split.sv @@
// ----------------------------------------------------------------------------
// ssd_digit_split: decimal split of a number below one thousand
// Hundreds, tens and units by reciprocal multiplication, no divider.
// ----------------------------------------------------------------------------
module ssd_digit_split (
  input  logic [ssd_pkg::NUMBER_W-1:0] number,
  output ssd_pkg::digit_t              hundreds,
  output ssd_pkg::digit_t              tens,
  output ssd_pkg::digit_t              units
);

  logic [15:0] hund_prod;
  logic [6:0]  rem_hund;
  logic [13:0] tens_prod;

  // 41/4096 approximates 1/100 exactly for inputs up to 999
  assign hund_prod = 16'(number) * 16'd41;
  assign hundreds  = hund_prod[15:12];
  assign rem_hund  = 7'(number - 10'(hundreds) * 10'd100);

  // 103/1024 approximates 1/10 exactly for inputs up to 99
  assign tens_prod = 14'(rem_hund) * 14'd103;
  assign tens      = tens_prod[13:10];
  assign units     = 4'(rem_hund - 7'(tens) * 7'd10);

endmodule

@@ rtl/seven_segment_scan_driver_unit.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit: four-position multiplexed display driver
// Results: an accepted tick lands in the output register, or in the skid
//   register while a result waits; updates change the patterns on that edge.
// Throughput: one request per cycle while the skid slot is free; the result
//   and skid registers keep requests flowing while one result waits on disp.
// Reset (rst, synchronous): patterns, scan position, blink counter and blink
//   enable clear; both result slots empty.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_unit (
  input  logic          clk,
  input  logic          rst,
  ssd_req_if.sink       cmd,
  ssd_res_if.source     disp
);

  // Display state
  ssd_pkg::pattern_t            patterns [ssd_pkg::POSITIONS];
  ssd_pkg::pattern_t            patterns_next [ssd_pkg::POSITIONS];
  logic [ssd_pkg::POS_W-1:0]    scan_position;
  logic [ssd_pkg::COUNT_W-1:0]  blink_counter;
  logic                         blink_enable;

  // Result slots: output register and skid register
  logic                          out_valid;
  ssd_pkg::pattern_t             out_levels;
  logic [ssd_pkg::POSITIONS-1:0] out_select;
  logic                          skid_valid;
  ssd_pkg::pattern_t             skid_levels;
  logic [ssd_pkg::POSITIONS-1:0] skid_select;

  logic                          accept;
  logic                          push;
  logic                          pop;
  ssd_pkg::pattern_t             new_levels;
  logic [ssd_pkg::POSITIONS-1:0] new_select;
  ssd_pkg::pattern_t             shown;

  logic [ssd_pkg::VALUE_W-1:0]   number_sat;
  logic [ssd_pkg::VALUE_W-1:0]   error_sat;
  ssd_pkg::digit_t               hundreds;
  ssd_pkg::digit_t               tens;
  ssd_pkg::digit_t               units;
  ssd_pkg::pattern_t             glyph_hundreds;
  ssd_pkg::pattern_t             glyph_tens;
  ssd_pkg::pattern_t             glyph_units;
  ssd_pkg::pattern_t             glyph_code;

  // Take requests while the skid slot is free: at most one result per request
  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign push      = accept && (cmd.operation == ssd_pkg::OP_TICK);
  assign pop       = out_valid && disp.ready;

  // Saturate number and error code before the digit split
  assign number_sat = (cmd.value > ssd_pkg::NUMBER_LIMIT) ? ssd_pkg::NUMBER_LIMIT : cmd.value;
  assign error_sat  = (cmd.value > ssd_pkg::ERROR_LIMIT) ? ssd_pkg::ERROR_LIMIT : cmd.value;

  ssd_digit_split u_split (
    .number   (number_sat[ssd_pkg::NUMBER_W-1:0]),
    .hundreds (hundreds),
    .tens     (tens),
    .units    (units)
  );

  // Glyphs for the three digit positions and the error code
  assign glyph_hundreds = ssd_pkg::glyph_of_digit(hundreds);
  assign glyph_tens     = ssd_pkg::glyph_of_digit(tens);
  assign glyph_units    = ssd_pkg::glyph_of_digit(units);
  assign glyph_code     = ssd_pkg::glyph_of_digit(error_sat[3:0]);

  // Blank digits 0..2 down to their point during the low half of the blink
  always_comb begin
    shown = patterns[scan_position];
    if (scan_position != 2'd3 && blink_enable && blink_counter <= ssd_pkg::BLINK_HALF) begin
      shown = shown & 8'h01;
    end
    new_levels = ~shown;
    new_select = ssd_pkg::POSITIONS'(1) << scan_position;
  end

  // Next pattern bytes; digit writes keep bit 0 so icons survive
  always_comb begin
    for (int p = 0; p < ssd_pkg::POSITIONS; p++) begin
      patterns_next[p] = patterns[p];
    end
    case (cmd.operation)
      ssd_pkg::OP_NUMBER: begin
        patterns_next[0] = {glyph_hundreds[7:1], patterns[0][0]};
        patterns_next[1] = {glyph_tens[7:1], patterns[1][0]};
        patterns_next[2] = {glyph_units[7:1], patterns[2][0]};
      end
      ssd_pkg::OP_ERROR: begin
        patterns_next[0] = {ssd_pkg::GLYPH_ERROR[7:1], patterns[0][0]};
        patterns_next[1] = {ssd_pkg::GLYPH_MINUS[7:1], patterns[1][0]};
        patterns_next[2] = {glyph_code[7:1], patterns[2][0]};
      end
      ssd_pkg::OP_ICON: begin
        if (cmd.icon_index < 4'(ssd_pkg::VOLUME_STEPS)) begin
          patterns_next[3][cmd.icon_index[2:0] + 3'd1] = cmd.switch_on;
        end else if (cmd.icon_index == ssd_pkg::ICON_POINT_1) begin
          patterns_next[1][0] = cmd.switch_on;
        end else if (cmd.icon_index == ssd_pkg::ICON_POINT_3) begin
          patterns_next[3][0] = cmd.switch_on;
        end else if (cmd.icon_index == ssd_pkg::ICON_POINT_2) begin
          patterns_next[2][0] = cmd.switch_on;
        end
      end
      ssd_pkg::OP_VOLUME: begin
        // Light bar step i when the level exceeds i
        for (int i = 0; i < ssd_pkg::VOLUME_STEPS; i++) begin
          patterns_next[3][i + 1] = (cmd.value > ssd_pkg::VALUE_W'(i));
        end
      end
      ssd_pkg::OP_CLEAR: begin
        for (int p = 0; p < ssd_pkg::POSITIONS; p++) begin
          patterns_next[p] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < ssd_pkg::POSITIONS; p++) begin
        patterns[p] <= '0;
      end
      scan_position <= '0;
      blink_counter <= '0;
      blink_enable  <= 1'b0;
    end else if (accept) begin
      for (int p = 0; p < ssd_pkg::POSITIONS; p++) begin
        patterns[p] <= patterns_next[p];
      end
      if (cmd.operation == ssd_pkg::OP_BLINK) begin
        blink_enable <= cmd.switch_on;
      end
      if (push) begin
        // Advance scan; count down, reloading the period in place of reaching zero
        scan_position <= scan_position + 2'd1;
        if (blink_counter <= 16'd1) begin
          blink_counter <= ssd_pkg::BLINK_PERIOD;
        end else begin
          blink_counter <= blink_counter - 16'd1;
        end
      end
    end
  end

  // Result slots: refill from skid on drain, otherwise drop new results in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_levels <= skid_levels;
        out_select <= skid_select;
      end else if (push) begin
        out_levels <= new_levels;
        out_select <= new_select;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_levels <= new_levels;
        out_select <= new_select;
      end else begin
        skid_levels <= new_levels;
        skid_select <= new_select;
      end
    end
  end

  assign disp.valid          = out_valid;
  assign disp.segment_levels = out_levels;
  assign disp.digit_select   = out_select;

  // Skid slot only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  // A presented result selects exactly one digit
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_select))
    else $error("digit select not one-hot");

  // Blink counter stays within one period
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    blink_counter <= ssd_pkg::BLINK_PERIOD)
    else $error("blink counter above period");

  // A tick into an empty output register shows up on the next edge
  a_tick_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("tick result lost");

endmodule
